[rtl/wia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_pkg
// Shared constants, operation codes and types of the integer ALU pipeline.
// ----------------------------------------------------------------------------
package wia_pkg;

  localparam int unsigned XLEN       = 64;
  localparam int unsigned HLEN       = 32;
  localparam int unsigned CMD_W      = 6;
  localparam int unsigned TRAP_W     = 2;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned MUL_STAGES = 2;
  localparam int unsigned MUL_DLY    = DIV_STEPS - MUL_STAGES;

  // Command space.
  localparam logic [CMD_W-1:0] CMD_WIDE_BASE = 6'd25;
  localparam logic [CMD_W-1:0] CMD_WIDE_LAST = 6'd47;
  localparam logic [CMD_W-1:0] CMD_LAND      = 6'd48;
  localparam logic [CMD_W-1:0] CMD_LOR       = 6'd49;

  // Operation codes within one width.
  localparam logic [4:0] OP_EQ    = 5'd0;
  localparam logic [4:0] OP_NE    = 5'd1;
  localparam logic [4:0] OP_LT_S  = 5'd2;
  localparam logic [4:0] OP_LT_U  = 5'd3;
  localparam logic [4:0] OP_LE_S  = 5'd4;
  localparam logic [4:0] OP_LE_U  = 5'd5;
  localparam logic [4:0] OP_GT_S  = 5'd6;
  localparam logic [4:0] OP_GT_U  = 5'd7;
  localparam logic [4:0] OP_GE_S  = 5'd8;
  localparam logic [4:0] OP_GE_U  = 5'd9;
  localparam logic [4:0] OP_ADD   = 5'd10;
  localparam logic [4:0] OP_SUB   = 5'd11;
  localparam logic [4:0] OP_MUL   = 5'd12;
  localparam logic [4:0] OP_DIV_S = 5'd13;
  localparam logic [4:0] OP_DIV_U = 5'd14;
  localparam logic [4:0] OP_REM_S = 5'd15;
  localparam logic [4:0] OP_REM_U = 5'd16;
  localparam logic [4:0] OP_SHL   = 5'd17;
  localparam logic [4:0] OP_SHR_S = 5'd18;
  localparam logic [4:0] OP_SHR_U = 5'd19;
  localparam logic [4:0] OP_AND   = 5'd20;
  localparam logic [4:0] OP_XOR   = 5'd21;
  localparam logic [4:0] OP_OR    = 5'd22;
  localparam logic [4:0] OP_EXT_S = 5'd23;
  localparam logic [4:0] OP_EXT_U = 5'd24;

  // Trap codes.
  localparam logic [TRAP_W-1:0] TRAP_NONE = 2'd0;
  localparam logic [TRAP_W-1:0] TRAP_DIV0 = 2'd1;
  localparam logic [TRAP_W-1:0] TRAP_OVF  = 2'd2;

  localparam logic [XLEN-1:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [XLEN-1:0] MIN32 = 64'hFFFF_FFFF_8000_0000;

  // Which unit produces the final word.
  typedef enum logic [2:0] {
    KIND_SIMPLE,
    KIND_MUL,
    KIND_DIVS,
    KIND_DIVU,
    KIND_REMS,
    KIND_REMU
  } kind_e;

  // Side information that travels alongside the long units.
  typedef struct packed {
    kind_e             kind;
    logic              wide;
    logic              neg;
    logic [TRAP_W-1:0] trap;
    logic [XLEN-1:0]   simple;
  } side_t;

  // Sign-extend the low half of a word.
  function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] x);
    sext32 = {{HLEN{x[HLEN-1]}}, x[HLEN-1:0]};
  endfunction

endpackage

[rtl/wia_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_front
// Decodes a command, computes all operations other than multiply, divide and
// remainder, and prepares the operands of the multiplier and the divider in one register stage.
// ----------------------------------------------------------------------------
module wia_front
  import wia_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [XLEN-1:0]   operand_a_i,
  input  logic [XLEN-1:0]   operand_b_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [XLEN-1:0]   mul_a_o,
  output logic [XLEN-1:0]   mul_b_o,
  output logic [XLEN-1:0]   div_n_o,
  output logic [XLEN-1:0]   div_d_o
);

  logic            wide, int_op;
  logic [4:0]      op;
  logic [XLEN-1:0] ua, ub, sa, sb, minv, mag_a, mag_b, res;
  logic [5:0]      sh;
  logic            eq, ltu, gtu, lts, gts, a_nz, b_nz;
  side_t           side_d;
  logic            valid_q;
  side_t           side_q;
  logic [XLEN-1:0] mul_a_q, mul_b_q, div_n_q, div_d_q;

  // Operand views for the selected width.
  always_comb begin
    int_op = (cmd_i <= CMD_WIDE_LAST);
    wide   = (cmd_i >= CMD_WIDE_BASE) && int_op;
    op     = wide ? 5'(cmd_i - CMD_WIDE_BASE) : cmd_i[4:0];
    ua     = wide ? operand_a_i : {{HLEN{1'b0}}, operand_a_i[HLEN-1:0]};
    ub     = wide ? operand_b_i : {{HLEN{1'b0}}, operand_b_i[HLEN-1:0]};
    sa     = wide ? operand_a_i : sext32(operand_a_i);
    sb     = wide ? operand_b_i : sext32(operand_b_i);
    minv   = wide ? MIN64 : MIN32;
    sh     = wide ? operand_b_i[5:0] : {1'b0, operand_b_i[4:0]};
    mag_a  = sa[XLEN-1] ? (XLEN'(0) - sa) : sa;
    mag_b  = sb[XLEN-1] ? (XLEN'(0) - sb) : sb;
    eq     = (ua == ub);
    ltu    = (ua < ub);
    gtu    = (ub < ua);
    lts    = ($signed(sa) < $signed(sb));
    gts    = ($signed(sb) < $signed(sa));
    a_nz   = (operand_a_i[HLEN-1:0] != '0);
    b_nz   = (operand_b_i[HLEN-1:0] != '0);
  end

  // Direct results and routing to the long units.
  always_comb begin
    res         = '0;
    side_d.kind = KIND_SIMPLE;
    side_d.wide = wide;
    side_d.neg  = 1'b0;
    side_d.trap = TRAP_NONE;
    unique case (op)
      OP_EQ:    res = XLEN'(eq);
      OP_NE:    res = XLEN'(!eq);
      OP_LT_S:  res = XLEN'(lts);
      OP_LT_U:  res = XLEN'(ltu);
      OP_LE_S:  res = XLEN'(!gts);
      OP_LE_U:  res = XLEN'(!gtu);
      OP_GT_S:  res = XLEN'(gts);
      OP_GT_U:  res = XLEN'(gtu);
      OP_GE_S:  res = XLEN'(!lts);
      OP_GE_U:  res = XLEN'(!ltu);
      OP_ADD:   res = ua + ub;
      OP_SUB:   res = ua - ub;
      OP_MUL:   side_d.kind = KIND_MUL;
      OP_DIV_S: begin
        side_d.kind = KIND_DIVS;
        side_d.neg  = sa[XLEN-1] ^ sb[XLEN-1];
      end
      OP_DIV_U: side_d.kind = KIND_DIVU;
      OP_REM_S: begin
        side_d.kind = KIND_REMS;
        side_d.neg  = sa[XLEN-1];
      end
      OP_REM_U: side_d.kind = KIND_REMU;
      OP_SHL:   res = ua << sh;
      OP_SHR_S: res = XLEN'($signed(sa) >>> sh);
      OP_SHR_U: res = ua >> sh;
      OP_AND:   res = ua & ub;
      OP_XOR:   res = ua ^ ub;
      OP_OR:    res = ua | ub;
      OP_EXT_S: res = sa;
      OP_EXT_U: res = ua;
      default:  res = '0;
    endcase
    // Narrow results are sign-extended, except the zero extension.
    if (!wide && op != OP_EXT_U) begin
      res = sext32(res);
    end
    // Division traps.
    if (side_d.kind == KIND_DIVS || side_d.kind == KIND_DIVU ||
        side_d.kind == KIND_REMS || side_d.kind == KIND_REMU) begin
      if (ub == '0) begin
        side_d.trap = TRAP_DIV0;
      end else if (side_d.kind == KIND_DIVS && sa == minv && sb == '1) begin
        side_d.trap = TRAP_OVF;
      end
    end
    // Logical and/or and unused codes.
    if (!int_op) begin
      side_d.kind = KIND_SIMPLE;
      side_d.neg  = 1'b0;
      side_d.trap = TRAP_NONE;
      if (cmd_i == CMD_LAND) begin
        res = XLEN'(a_nz && b_nz);
      end else if (cmd_i == CMD_LOR) begin
        res = XLEN'(a_nz || b_nz);
      end else begin
        res = '0;
      end
    end
    side_d.simple = res;
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    side_q  <= side_d;
    mul_a_q <= ua;
    mul_b_q <= ub;
    div_n_q <= (side_d.kind == KIND_DIVS || side_d.kind == KIND_REMS) ? mag_a : ua;
    div_d_q <= (side_d.kind == KIND_DIVS || side_d.kind == KIND_REMS) ? mag_b : ub;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign mul_a_o = mul_a_q;
  assign mul_b_o = mul_b_q;
  assign div_n_o = div_n_q;
  assign div_d_o = div_d_q;

endmodule

[rtl/wia_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_mul
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product from
// three 32 by 32 partial products.
// ----------------------------------------------------------------------------
module wia_mul
  import wia_pkg::*;
(
  input  logic            clk_i,
  input  logic [XLEN-1:0] a_i,
  input  logic [XLEN-1:0] b_i,
  output logic [XLEN-1:0] prod_o
);

  logic [XLEN-1:0] p_ll_q, prod_q;
  logic [HLEN-1:0] p_lh_q, p_hl_q;
  logic [XLEN-1:0] p_lh_full, p_hl_full;

  assign p_lh_full = a_i[HLEN-1:0] * b_i[XLEN-1:HLEN];
  assign p_hl_full = a_i[XLEN-1:HLEN] * b_i[HLEN-1:0];

  // First stage: partial products.
  always_ff @(posedge clk_i) begin
    p_ll_q <= a_i[HLEN-1:0] * b_i[HLEN-1:0];
    p_lh_q <= p_lh_full[HLEN-1:0];
    p_hl_q <= p_hl_full[HLEN-1:0];
  end

  // Second stage: sum of the partial products.
  always_ff @(posedge clk_i) begin
    prod_q <= p_ll_q + {p_lh_q + p_hl_q, {HLEN{1'b0}}};
  end

  assign prod_o = prod_q;

endmodule

[rtl/wia_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_div
// Fully pipelined unsigned restoring divider: one quotient bit per stage,
// 64 stages, giving quotient and remainder.
// ----------------------------------------------------------------------------
module wia_div
  import wia_pkg::*;
(
  input  logic            clk_i,
  input  logic [XLEN-1:0] num_i,
  input  logic [XLEN-1:0] den_i,
  output logic [XLEN-1:0] quo_o,
  output logic [XLEN-1:0] rem_o
);

  logic [XLEN-1:0] rem_q [DIV_STEPS+1];
  logic [XLEN-1:0] num_q [DIV_STEPS+1];
  logic [XLEN-1:0] den_q [DIV_STEPS+1];

  assign rem_q[0] = '0;
  assign num_q[0] = num_i;
  assign den_q[0] = den_i;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [XLEN:0] trial;
    logic [XLEN:0] diff;
    logic          fits;

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
      trial = {rem_q[k], num_q[k][XLEN-1]};
      diff  = trial - {1'b0, den_q[k]};
      fits  = (trial >= {1'b0, den_q[k]});
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= fits ? diff[XLEN-1:0] : trial[XLEN-1:0];
      num_q[k+1] <= {num_q[k][XLEN-2:0], fits};
      den_q[k+1] <= den_q[k];
    end
  end

  assign quo_o = num_q[DIV_STEPS];
  assign rem_o = rem_q[DIV_STEPS];

endmodule

[rtl/wasm_integer_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wasm_integer_alu
// Integer ALU for the i32 and i64 operations of a WebAssembly core.
// ----------------------------------------------------------------------------
// Pipeline: the decode register captures the word at the accepting edge, then
// come the 64-stage pipelined divider and the output register; every operation
// takes this same path before the done strobe rises. Throughput: one word
// per cycle; busy_o is always low. Reset clears only the valid bits; no word
// is in flight after reset. Results cannot be stalled; each is shown for
// exactly one cycle.
// ----------------------------------------------------------------------------
module wasm_integer_alu
  import wia_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [XLEN-1:0]   operand_a_i,
  input  logic [XLEN-1:0]   operand_b_i,
  output logic              done_o,
  output logic [XLEN-1:0]   result_o,
  output logic [TRAP_W-1:0] trap_o
);

  logic            f_valid;
  side_t           f_side;
  logic [XLEN-1:0] mul_a, mul_b, div_n, div_d, prod, quo, rem;

  logic            vld_q  [DIV_STEPS];
  side_t           side_q [DIV_STEPS];
  logic [XLEN-1:0] prod_q [MUL_DLY];

  logic [XLEN-1:0]   res_d, res_q;
  logic              done_q;
  logic [TRAP_W-1:0] trap_q;
  side_t             s_end;

  assign busy_o = 1'b0;

  wia_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (f_valid),
    .side_o      (f_side),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .div_n_o     (div_n),
    .div_d_o     (div_d)
  );

  wia_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  wia_div u_div (
    .clk_i (clk_i),
    .num_i (div_n),
    .den_i (div_d),
    .quo_o (quo),
    .rem_o (rem)
  );

  // Valid bits alongside the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= f_valid;
      for (int i = 1; i < DIV_STEPS; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Side information and product delay lines.
  always_ff @(posedge clk_i) begin
    side_q[0] <= f_side;
    for (int i = 1; i < DIV_STEPS; i++) begin
      side_q[i] <= side_q[i-1];
    end
    prod_q[0] <= prod;
    for (int i = 1; i < MUL_DLY; i++) begin
      prod_q[i] <= prod_q[i-1];
    end
  end

  // Final selection, sign fix and narrowing.
  always_comb begin
    s_end = side_q[DIV_STEPS-1];
    case (s_end.kind)
      KIND_SIMPLE: res_d = s_end.simple;
      KIND_MUL:    res_d = prod_q[MUL_DLY-1];
      KIND_DIVS:   res_d = s_end.neg ? (XLEN'(0) - quo) : quo;
      KIND_DIVU:   res_d = quo;
      KIND_REMS:   res_d = s_end.neg ? (XLEN'(0) - rem) : rem;
      KIND_REMU:   res_d = rem;
      default:     res_d = '0;
    endcase
    if (!s_end.wide && s_end.kind != KIND_SIMPLE) begin
      res_d = sext32(res_d);
    end
    if (s_end.trap != TRAP_NONE) begin
      res_d = '0;
    end
  end

  // Output strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[DIV_STEPS-1];
    end
  end

  // Output word.
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    trap_q <= s_end.trap;
  end

  assign done_o   = done_q;
  assign result_o = res_q;
  assign trap_o   = trap_q;

endmodule

[tb/sv/tb_wasm_integer_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wasm_integer_alu
// Self-checking bench for the WebAssembly integer ALU. A queue of operation
// words feeds a clocked driver, and a clocked monitor compares every result
// word against an independent prediction computed when the word is accepted.
// ----------------------------------------------------------------------------
module tb_wasm_integer_alu;
  import wia_pkg::*;

  localparam int unsigned LATENCY   = 66;
  localparam int unsigned MAX_CYCLE = 400000;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [XLEN-1:0]  a;
    logic [XLEN-1:0]  b;
  } alu_word_t;

  typedef struct {
    logic [XLEN-1:0]   result;
    logic [TRAP_W-1:0] trap;
  } alu_answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [CMD_W-1:0]  cmd_i = '0;
  logic [XLEN-1:0]   operand_a_i = '0;
  logic [XLEN-1:0]   operand_b_i = '0;
  logic              done_o;
  logic [XLEN-1:0]   result_o;
  logic [TRAP_W-1:0] trap_o;

  alu_word_t   pending_words[$];
  alu_answer_t expected_answers[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;

  wasm_integer_alu uut (.*);

  // Clock generation.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predict the answer for one operation word.
  function automatic alu_answer_t alu_predict(alu_word_t w);
    alu_answer_t ans;
    logic              wide;
    logic [4:0]        op;
    logic [XLEN-1:0]   ua, ub, sa, sb, minv, r, qa, qb, q;
    logic [TRAP_W-1:0] tr;
    int unsigned       sh;
    wide = (w.cmd >= CMD_WIDE_BASE);
    op = wide ? 5'(w.cmd - CMD_WIDE_BASE) : w.cmd[4:0];
    ua = wide ? w.a : {32'd0, w.a[31:0]};
    ub = wide ? w.b : {32'd0, w.b[31:0]};
    sa = wide ? w.a : {{32{w.a[31]}}, w.a[31:0]};
    sb = wide ? w.b : {{32{w.b[31]}}, w.b[31:0]};
    minv = wide ? MIN64 : MIN32;
    sh = wide ? w.b[5:0] : w.b[4:0];
    r = '0;
    tr = TRAP_NONE;
    qa = sa[63] ? -sa : sa;
    qb = sb[63] ? -sb : sb;
    if (w.cmd <= CMD_WIDE_LAST) begin
      case (op)
        OP_EQ:   r = ua == ub;
        OP_NE:   r = ua != ub;
        OP_LT_S: r = $signed(sa) < $signed(sb);
        OP_LT_U: r = ua < ub;
        OP_LE_S: r = $signed(sa) <= $signed(sb);
        OP_LE_U: r = ua <= ub;
        OP_GT_S: r = $signed(sa) > $signed(sb);
        OP_GT_U: r = ua > ub;
        OP_GE_S: r = $signed(sa) >= $signed(sb);
        OP_GE_U: r = ua >= ub;
        OP_ADD:  r = ua + ub;
        OP_SUB:  r = ua - ub;
        OP_MUL:  r = ua * ub;
        OP_DIV_S: begin
          if (ub == 0) tr = TRAP_DIV0;
          else if (sa == minv && sb == '1) tr = TRAP_OVF;
          else begin
            q = qa / qb;
            r = (sa[63] ^ sb[63]) ? -q : q;
          end
        end
        OP_DIV_U: if (ub == 0) tr = TRAP_DIV0; else r = ua / ub;
        OP_REM_S: begin
          if (ub == 0) tr = TRAP_DIV0;
          else begin
            q = qa % qb;
            r = sa[63] ? -q : q;
          end
        end
        OP_REM_U: if (ub == 0) tr = TRAP_DIV0; else r = ua % ub;
        OP_SHL:   r = ua << sh;
        OP_SHR_S: r = $signed(sa) >>> sh;
        OP_SHR_U: r = ua >> sh;
        OP_AND:   r = ua & ub;
        OP_XOR:   r = ua ^ ub;
        OP_OR:    r = ua | ub;
        OP_EXT_S: r = sa;
        default:  r = ua;
      endcase
      // Narrow results come back sign-extended, except the zero extension.
      if (!wide && op != OP_EXT_U) r = {{32{r[31]}}, r[31:0]};
    end else if (w.cmd == CMD_LAND) begin
      r = (w.a[31:0] != 0) && (w.b[31:0] != 0);
    end else if (w.cmd == CMD_LOR) begin
      r = (w.a[31:0] != 0) || (w.b[31:0] != 0);
    end
    if (tr != TRAP_NONE) r = '0;
    ans.result = r;
    ans.trap = tr;
    return ans;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic logic [XLEN-1:0] rand_word();
    logic [XLEN-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = MIN64;
      3: v = MIN32;
      4: v = 64'($urandom_range(0, 70));
      5: v = {$urandom, 32'h8000_0000};
      default: ;
    endcase
    return v;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic add_word(logic [CMD_W-1:0] c, logic [XLEN-1:0] a, logic [XLEN-1:0] b);
    alu_word_t w;
    w.cmd = c;
    w.a = a;
    w.b = b;
    pending_words.push_back(w);
  endtask

  // Driver: presents queued words, changing inputs on the falling edge.
  // While start_i is high, the word on the inputs is the head of the queue; it leaves the
  // queue once it has been accepted.
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && busy_o)) begin
      if (start_i && !busy_o) void'(pending_words.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        alu_word_t w;
        w = pending_words[0];
        start_i <= 1'b1;
        cmd_i <= w.cmd;
        operand_a_i <= w.a;
        operand_b_i <= w.b;
        gap_left <= rand_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts on acceptance and checks each done strobe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (start_i && !busy_o) begin
        alu_word_t w;
        w.cmd = cmd_i;
        w.a = operand_a_i;
        w.b = operand_b_i;
        expected_answers.push_back(alu_predict(w));
      end
      if (done_o) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          alu_answer_t e;
          e = expected_answers.pop_front();
          if (result_o !== e.result)
            report_mismatch($sformatf("result %h, expected %h", result_o, e.result));
          if (trap_o !== e.trap)
            report_mismatch($sformatf("trap %0d, expected %0d", trap_o, e.trap));
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    if (cycle_count > MAX_CYCLE) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int c;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed: every code with edge operands, then the division, shift and logical corners.
    for (c = 0; c < 64; c++) add_word(CMD_W'(c), '1, 64'h0000_0001_8000_0001);
    add_word(CMD_WIDE_BASE + OP_DIV_S, MIN64, '1);
    add_word(OP_DIV_S, MIN32, 64'h0000_0000_FFFF_FFFF);
    add_word(CMD_WIDE_BASE + OP_REM_S, MIN64, '1);
    add_word(OP_REM_S, 64'h0000_0000_8000_0000, '1);
    add_word(OP_DIV_U, 64'h5, 64'hFFFF_FFFF_0000_0000);
    add_word(CMD_WIDE_BASE + OP_REM_U, 64'h5, '0);
    add_word(OP_SHL, 64'h1, 64'h3F);
    add_word(CMD_WIDE_BASE + OP_SHR_S, MIN64, 64'h7F);
    add_word(CMD_LAND, 64'hFFFF_FFFF_0000_0000, 64'h1);
    add_word(CMD_LOR, '0, 64'hFFFF_FFFF_0000_0000);
    // Hold off until everything so far has been checked.
    while (pending_words.size() > 0 || expected_answers.size() > 0) @(posedge clk_i);
    for (c = 0; c < 650; c++) begin
      int k;
      k = $urandom_range(0, 19);
      add_word(k == 0 ? CMD_W'($urandom_range(0, 63)) : CMD_W'($urandom_range(0, 49)),
               rand_word(), rand_word());
    end
    while (pending_words.size() > 0 || expected_answers.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[wasm_integer_alu.f]
rtl/wia_pkg.sv
rtl/wia_front.sv
rtl/wia_mul.sv
rtl/wia_div.sv
rtl/wasm_integer_alu.sv
tb/sv/tb_wasm_integer_alu.sv
